// ===== rtl/igt_pkg.sv =====
package igt_pkg;

    // Field widths fixed by the register map and the stream payload
    localparam int SRC_W   = 9;   // src_width / src_height and load counters
    localparam int OUT_W   = 11;  // out_width / out_height and emit counters
    localparam int ORG_W   = 8;   // crop origins
    localparam int MODE_W  = 2;
    localparam int CMD_W   = 2;
    localparam int PIX_W   = 32;
    localparam int DEST_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Source coordinate width: holds origin plus the widest emit column
    localparam int COORD_W = 12;
    // Scale product x * src_w and its quotient (quotient is below src_w)
    localparam int PROD_W  = OUT_W + SRC_W;
    localparam int QUOT_W  = SRC_W;

    // Payload widths on the streams
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Modes
    localparam logic [MODE_W-1:0] MODE_SCALE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CROP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROT_R = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ROT_L = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd6;

    typedef logic [PIX_W-1:0] pixel_t;

endpackage

// ===== rtl/igt_ram.sv =====
module igt_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/igt_div.sv =====
module igt_div
    import igt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [OUT_W-1:0]  divisor,
    output logic              busy,
    output logic [QUOT_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [OUT_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] bits_reg;     // dividend low bits in, quotient bits out
    logic [OUT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [OUT_W:0]    trial;
    logic              fits;

    // Restoring step: one quotient bit per cycle
    assign trial = {rem_reg, bits_reg[QUOT_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Quotient is known to fit QUOT_W bits, so the top part starts below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend[PROD_W-1:QUOT_W];
            bits_reg <= dividend[QUOT_W-1:0];
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? OUT_W'(trial - {1'b0, div_reg}) : trial[OUT_W-1:0];
            bits_reg <= {bits_reg[QUOT_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = bits_reg;

endmodule

// ===== rtl/image_geometry_transform.sv =====
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tdata: pixel_in; s_tuser: command
// m_*       out  m_tvalid / m_tready    m_tdata: pixel_out, dest_x, dest_y;
//                                       m_tlast: frame_last; m_tuser: error
// cfg_*     in   cfg_valid / cfg_ready  cfg_index: register, cfg_data: value
//
// Load and restart requests complete when accepted. An emit request steps
// through coordinate, frame-store read and output in crop and rotate modes;
// scale mode adds a divide step, where two 9-step restoring dividers work out
// the source column and row. One frame-store read per emitted pixel. Reset
// clears counters and m_tvalid, presets config; the frame store is not cleared.
// A result waiting in the output register does not block loads; an emit waits
// for the output register to free before it completes.
module image_geometry_transform
    import igt_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_OUT    = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [31:0] pixel_in
    input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [31:0] pixel_out, [41:32] dest_x,
                                             // [51:42] dest_y, [55:52] zero
    output logic                  m_tlast,   // frame_last
    output logic [0:0]            m_tuser,   // [0] error

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    // Configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [SRC_W-1:0]  src_width_reg, src_height_reg;
    logic [OUT_W-1:0]  out_width_reg, out_height_reg;
    logic [ORG_W-1:0]  origin_x_reg, origin_y_reg;

    // Counters
    logic [SRC_W-1:0]  load_col_reg, load_row_reg, load_col_next, load_row_next;
    logic [OUT_W-1:0]  emit_col_reg, emit_row_reg, emit_col_next, emit_row_next;

    // Current emit item
    logic [OUT_W-1:0]   x_reg, y_reg;
    logic [COORD_W-1:0] sx_reg, sy_reg;
    logic               err_reg, last_reg;

    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tvalid_reg, m_tlast_reg, m_error_reg;

    logic [SRC_W-1:0]  sw, sh;
    logic [OUT_W-1:0]  ow, oh;
    logic              in_accept, out_free;
    logic              div_start, div_x_busy, div_y_busy;
    logic [QUOT_W-1:0] quot_x, quot_y;
    logic [PIX_W-1:0]  rd_data;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              wr_en, rd_en;

    // Load counter pre-wrap and step
    logic [SRC_W:0]    lr_a, lc_inc, lr_b;
    logic [SRC_W-1:0]  lc_pre, lr_pre;
    // Emit counter pre-wrap and step
    logic [OUT_W:0]    er_a, nx, ny;
    logic [OUT_W-1:0]  ec_pre, er_pre;
    // Crop coordinates
    logic [COORD_W-1:0] crop_x, crop_y;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Effective sizes: zero acts as one, oversize saturates
    assign sw = (src_width_reg == '0) ? SRC_W'(1) :
                (src_width_reg > MAX_WIDTH) ? SRC_W'(MAX_WIDTH) : src_width_reg;
    assign sh = (src_height_reg == '0) ? SRC_W'(1) :
                (src_height_reg > MAX_HEIGHT) ? SRC_W'(MAX_HEIGHT) : src_height_reg;

    always_comb
    begin
        if (mode_reg == MODE_ROT_R || mode_reg == MODE_ROT_L)
        begin
            ow = OUT_W'(sh);
            oh = OUT_W'(sw);
        end
        else
        begin
            ow = (out_width_reg == '0) ? OUT_W'(1) :
                 (out_width_reg > MAX_OUT) ? OUT_W'(MAX_OUT) : out_width_reg;
            oh = (out_height_reg == '0) ? OUT_W'(1) :
                 (out_height_reg > MAX_OUT) ? OUT_W'(MAX_OUT) : out_height_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SCALE;
            src_width_reg  <= SRC_W'(1);
            src_height_reg <= SRC_W'(1);
            out_width_reg  <= OUT_W'(1);
            out_height_reg <= OUT_W'(1);
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[MODE_W-1:0];
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data[OUT_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= cfg_data[OUT_W-1:0];
                REG_ORIGIN_X:   origin_x_reg   <= cfg_data[ORG_W-1:0];
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_data[ORG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Load position: wrap onto the current size, then step past the written pixel
    always_comb
    begin
        lr_a   = (load_col_reg >= sw) ? ({1'b0, load_row_reg} + 1'b1) : {1'b0, load_row_reg};
        lc_pre = (load_col_reg >= sw) ? '0 : load_col_reg;
        lr_pre = (lr_a >= {1'b0, sh}) ? '0 : lr_a[SRC_W-1:0];
        lc_inc = {1'b0, lc_pre} + 1'b1;
        lr_b   = {1'b0, lr_pre} + 1'b1;
        if (lc_inc >= {1'b0, sw})
        begin
            load_col_next = '0;
            load_row_next = (lr_b >= {1'b0, sh}) ? '0 : lr_b[SRC_W-1:0];
        end
        else
        begin
            load_col_next = lc_inc[SRC_W-1:0];
            load_row_next = lr_pre;
        end
    end

    assign wr_en   = in_accept && s_tuser == CMD_LOAD;
    assign wr_addr = ADDR_W'(lr_pre) * ADDR_W'(MAX_WIDTH) + ADDR_W'(lc_pre);

    // Emit position wrapped onto the current frame size
    always_comb
    begin
        er_a   = (emit_col_reg >= ow) ? ({1'b0, emit_row_reg} + 1'b1) : {1'b0, emit_row_reg};
        ec_pre = (emit_col_reg >= ow) ? '0 : emit_col_reg;
        er_pre = (er_a >= {1'b0, oh}) ? '0 : er_a[OUT_W-1:0];
    end

    // Raster step after the current pixel
    always_comb
    begin
        nx = {1'b0, x_reg} + 1'b1;
        ny = {1'b0, y_reg} + 1'b1;
        if (nx >= {1'b0, ow})
        begin
            emit_col_next = '0;
            emit_row_next = (ny >= {1'b0, oh}) ? '0 : ny[OUT_W-1:0];
        end
        else
        begin
            emit_col_next = nx[OUT_W-1:0];
            emit_row_next = y_reg;
        end
    end

    assign crop_x = COORD_W'(origin_x_reg) + COORD_W'(x_reg);
    assign crop_y = COORD_W'(origin_y_reg) + COORD_W'(y_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && s_tuser == CMD_EMIT)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC: state_next = (mode_reg == MODE_SCALE) ? S_DIV : S_READ;
            S_DIV:
            begin
                if (!div_x_busy && !div_y_busy)
                begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_col_reg <= '0;
            load_row_reg <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
        end
        else if (in_accept && s_tuser == CMD_RESTART)
        begin
            load_col_reg <= '0;
            load_row_reg <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
        end
        else if (wr_en)
        begin
            load_col_reg <= load_col_next;
            load_row_reg <= load_row_next;
        end
        else if (state_reg == S_CALC)
        begin
            emit_col_reg <= emit_col_next;
            emit_row_reg <= emit_row_next;
        end
    end

    // Per-pixel coordinate registers
    always_ff @(posedge clk)
    begin
        if (in_accept && s_tuser == CMD_EMIT)
        begin
            x_reg <= ec_pre;
            y_reg <= er_pre;
        end
        if (state_reg == S_CALC)
        begin
            last_reg <= (x_reg == ow - 1'b1) && (y_reg == oh - 1'b1);
            err_reg  <= 1'b0;
            unique case (mode_reg)
                MODE_SCALE:
                begin
                    sx_reg <= '0;
                    sy_reg <= '0;
                end
                MODE_CROP:
                begin
                    sx_reg  <= crop_x;
                    sy_reg  <= crop_y;
                    err_reg <= (crop_x >= COORD_W'(sw)) || (crop_y >= COORD_W'(sh));
                end
                MODE_ROT_R:
                begin
                    sx_reg <= COORD_W'(y_reg);
                    sy_reg <= COORD_W'(sh) - COORD_W'(1) - COORD_W'(x_reg);
                end
                default:
                begin
                    sx_reg <= COORD_W'(sw) - COORD_W'(1) - COORD_W'(y_reg);
                    sy_reg <= COORD_W'(x_reg);
                end
            endcase
        end
        else if (state_reg == S_DIV && !div_x_busy && !div_y_busy)
        begin
            sx_reg <= COORD_W'(quot_x);
            sy_reg <= COORD_W'(quot_y);
        end
    end

    // Scale quotients: x*sw/ow and y*sh/oh
    assign div_start = state_reg == S_CALC && mode_reg == MODE_SCALE;

    igt_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (PROD_W'(x_reg) * PROD_W'(sw)),
        .divisor  (ow),
        .busy     (div_x_busy),
        .quotient (quot_x)
    );

    igt_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (PROD_W'(y_reg) * PROD_W'(sh)),
        .divisor  (oh),
        .busy     (div_y_busy),
        .quotient (quot_y)
    );

    // Frame store
    assign rd_en   = state_reg == S_READ;
    assign rd_addr = ADDR_W'(sy_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx_reg);

    igt_ram
    #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    )
    u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[PIX_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            m_tdata_reg <= {(M_DATA_W - PIX_W - 2 * DEST_W)'(0),
                            y_reg[DEST_W-1:0], x_reg[DEST_W-1:0],
                            err_reg ? '0 : rd_data};
            m_tlast_reg <= last_reg;
            m_error_reg <= err_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_error_reg;

endmodule
